// File: rtl/core/orls_pkg.sv
// Package for the occluding rectangle list splitter.
// Holds payload widths, status codes and the controller/datapath command
// and status bundles. No dependencies.
package orls_pkg;

   localparam int FIELD_BITS  = 16;
   localparam int TAG_BITS    = 5;
   localparam int STATUS_BITS = 2;

   // Per-item status codes
   localparam logic [STATUS_BITS-1:0] STATUS_STORED  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_DROPPED = 2'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // latch the new rectangle, clear per-item counters
      logic scan_rd;    // read the table entry at the scan index
      logic scan_ev;    // test overlap, free the hit slot, latch the old edges
      logic scan_next;  // advance the scan index
      logic piece_do;   // place or drop the current piece
      logic dec_do;     // lower the owner count, log a release when it reaches zero
      logic new_do;     // store the new rectangle, or log its tag as released when no slot is free
      logic emit_rd;    // read the release log
      logic emit_ld;    // load one result into the output register
   } orls_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic empty;
      logic scan_valid;
      logic scan_last;
      logic hit;
      logic piece_last;
      logic out_free;
      logic rel_last;
   } orls_sts_type;

endpackage

// File: rtl/core/orls_if.sv
// Handshake interfaces for the request and response channels.
// Depends on orls_pkg for the field widths.
interface orls_req_if;
   import orls_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] rect_top;
   logic signed [FIELD_BITS-1:0] rect_left;
   logic signed [FIELD_BITS-1:0] rect_bottom;
   logic signed [FIELD_BITS-1:0] rect_right;
   logic [TAG_BITS-1:0]          owner_tag;

   modport source (output valid, rect_top, rect_left, rect_bottom, rect_right, owner_tag,
                   input ready);
   modport sink (input valid, rect_top, rect_left, rect_bottom, rect_right, owner_tag,
                 output ready);
endinterface

interface orls_rsp_if;
   import orls_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [TAG_BITS-1:0]    released_tag;
   logic                   release_valid;
   logic                   last_item;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, released_tag, release_valid, last_item, status,
                   input ready);
   modport sink (input valid, released_tag, release_valid, last_item, status,
                 output ready);
endinterface

// File: rtl/core/orls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module orls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/orls_ctrl.sv
// Controller state machine for the rectangle list splitter.
// Depends on orls_pkg for the command and status bundles.
module orls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  orls_pkg::orls_sts_type sts,
   output orls_pkg::orls_cmd_type cmd
);
   import orls_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_CHECK   = 9'b000000010,
      S_SCAN    = 9'b000000100,
      S_EVAL    = 9'b000001000,
      S_PIECE   = 9'b000010000,
      S_DEC     = 9'b000100000,
      S_NEW     = 9'b001000000,
      S_EMIT_RD = 9'b010000000,
      S_EMIT_LD = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = sts.empty ? S_EMIT_LD : S_SCAN;
         end
         S_SCAN: begin
            if (sts.scan_valid) begin
               cmd.scan_rd = 1'b1;
               state_in    = S_EVAL;
            end else if (sts.scan_last) begin
               state_in = S_NEW;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_EVAL: begin
            cmd.scan_ev = 1'b1;
            if (sts.hit) begin
               state_in = S_PIECE;
            end else if (sts.scan_last) begin
               state_in = S_NEW;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_PIECE: begin
            cmd.piece_do = 1'b1;
            if (sts.piece_last) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            cmd.dec_do = 1'b1;
            if (sts.scan_last) begin
               state_in = S_NEW;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_NEW: begin
            cmd.new_do = 1'b1;
            state_in   = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.emit_ld = 1'b1;
               state_in    = sts.rel_last ? S_IDLE : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: rtl/core/orls_dp.sv
// Datapath: rectangle table, owner counts, release log and output register.
// Depends on orls_pkg and orls_ram.
module orls_dp #(
   parameter int RECT_SLOTS = 32,
   parameter int TAG_SLOTS  = 32,
   parameter int COORD_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  orls_pkg::orls_cmd_type                    cmd,
   output orls_pkg::orls_sts_type                    sts,
   input  logic signed [orls_pkg::FIELD_BITS-1:0]    req_top,
   input  logic signed [orls_pkg::FIELD_BITS-1:0]    req_left,
   input  logic signed [orls_pkg::FIELD_BITS-1:0]    req_bottom,
   input  logic signed [orls_pkg::FIELD_BITS-1:0]    req_right,
   input  logic [orls_pkg::TAG_BITS-1:0]             req_tag,
   input  logic                                      rsp_ready,
   output logic                                      rsp_valid,
   output logic [orls_pkg::TAG_BITS-1:0]             rsp_tag,
   output logic                                      rsp_rel_valid,
   output logic                                      rsp_last,
   output logic [orls_pkg::STATUS_BITS-1:0]          rsp_status
);
   import orls_pkg::*;

   localparam int SLOT_W  = $clog2(RECT_SLOTS);
   localparam int FREE_W  = $clog2(RECT_SLOTS + 1);
   localparam int REL_D   = RECT_SLOTS + 1;
   localparam int REL_AW  = $clog2(REL_D);
   localparam int REL_CW  = $clog2(REL_D + 1);
   localparam int REF_W   = $clog2(RECT_SLOTS + 2);
   localparam int TIDX_W  = $clog2(TAG_SLOTS);
   localparam int ENTRY_W = 4 * COORD_BITS + TAG_BITS;
   localparam int RED_W   = TAG_BITS + 1;

   // Fold a tag onto the count table by repeated subtraction
   function automatic logic [TIDX_W-1:0] tag_fold(input logic [TAG_BITS-1:0] tag);
      logic [RED_W-1:0] r;
      r = RED_W'(tag);
      for (int s = 0; s < 8; s++) begin
         if (32'(r) >= TAG_SLOTS) begin
            r = r - RED_W'(TAG_SLOTS);
         end
      end
      return TIDX_W'(r);
   endfunction

   // New rectangle and item state
   logic signed [COORD_BITS-1:0] nr_top_ff, nr_left_ff, nr_bottom_ff, nr_right_ff;
   logic [TAG_BITS-1:0]          tag_ff;
   logic [SLOT_W-1:0]            idx_ff;
   logic                         dropped_ff;
   logic [REL_CW-1:0]            rel_cnt_ff;
   logic [REL_CW-1:0]            emit_ff;

   // Overlapped entry being split
   logic signed [COORD_BITS-1:0] old_top_ff, old_left_ff, old_bottom_ff, old_right_ff;
   logic [TAG_BITS-1:0]          own_ff;
   logic [3:0]                   mask_ff;
   logic [1:0]                   k_ff;

   // Table bookkeeping
   logic [RECT_SLOTS-1:0] valid_ff;
   logic [FREE_W-1:0]     free_ff;
   logic [REF_W-1:0]      refs_ff [TAG_SLOTS];

   // Output register
   logic                   rsp_valid_ff;
   logic [TAG_BITS-1:0]    rsp_tag_ff;
   logic                   rsp_rel_ff;
   logic                   rsp_last_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;

   // Memories
   logic                 ent_wr_en;
   logic [SLOT_W-1:0]    ent_wr_addr;
   logic [ENTRY_W-1:0]   ent_wr_data;
   logic [ENTRY_W-1:0]   ent_rd_data;
   logic                 rel_wr_en;
   logic [TAG_BITS-1:0]  rel_wr_data;
   logic [TAG_BITS-1:0]  rel_rd_data;

   orls_ram #(.WIDTH(ENTRY_W), .DEPTH(RECT_SLOTS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (cmd.scan_rd),
      .rd_addr (idx_ff),
      .rd_data (ent_rd_data)
   );

   orls_ram #(.WIDTH(TAG_BITS), .DEPTH(REL_D)) u_rel_ram (
      .clock   (clock),
      .wr_en   (rel_wr_en),
      .wr_addr (rel_cnt_ff[REL_AW-1:0]),
      .wr_data (rel_wr_data),
      .rd_en   (cmd.emit_rd),
      .rd_addr (emit_ff[REL_AW-1:0]),
      .rd_data (rel_rd_data)
   );

   // Unpack the entry just read
   logic signed [COORD_BITS-1:0] rd_top, rd_left, rd_bottom, rd_right;
   logic [TAG_BITS-1:0]          rd_own;
   assign rd_right  = $signed(ent_rd_data[COORD_BITS-1:0]);
   assign rd_bottom = $signed(ent_rd_data[2*COORD_BITS-1:COORD_BITS]);
   assign rd_left   = $signed(ent_rd_data[3*COORD_BITS-1:2*COORD_BITS]);
   assign rd_top    = $signed(ent_rd_data[4*COORD_BITS-1:3*COORD_BITS]);
   assign rd_own    = ent_rd_data[ENTRY_W-1:4*COORD_BITS];

   logic hit;
   assign hit = (rd_left < nr_right_ff) && (rd_right > nr_left_ff) &&
                (rd_top < nr_bottom_ff) && (rd_bottom > nr_top_ff);

   // Lowest free slot
   logic [SLOT_W-1:0] low_free;
   always_comb begin
      low_free = '0;
      for (int i = RECT_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            low_free = SLOT_W'(i);
         end
      end
   end

   // Current piece edges: top, bottom, left, right strips in that order
   logic signed [COORD_BITS-1:0] mid_top, mid_bottom;
   logic signed [COORD_BITS-1:0] pc_top, pc_left, pc_bottom, pc_right;
   assign mid_top    = (old_top_ff > nr_top_ff) ? old_top_ff : nr_top_ff;
   assign mid_bottom = (old_bottom_ff < nr_bottom_ff) ? old_bottom_ff : nr_bottom_ff;
   always_comb begin
      unique case (k_ff)
         2'd0: begin
            pc_top = old_top_ff; pc_left = old_left_ff;
            pc_bottom = nr_top_ff; pc_right = old_right_ff;
         end
         2'd1: begin
            pc_top = nr_bottom_ff; pc_left = old_left_ff;
            pc_bottom = old_bottom_ff; pc_right = old_right_ff;
         end
         2'd2: begin
            pc_top = mid_top; pc_left = old_left_ff;
            pc_bottom = mid_bottom; pc_right = nr_left_ff;
         end
         default: begin
            pc_top = mid_top; pc_left = nr_right_ff;
            pc_bottom = mid_bottom; pc_right = old_right_ff;
         end
      endcase
   end

   logic [TIDX_W-1:0] own_idx, tag_idx;
   logic [REF_W-1:0]  own_ref, own_dec;
   logic              place_piece, place_new;
   assign own_idx     = tag_fold(own_ff);
   assign tag_idx     = tag_fold(tag_ff);
   assign own_ref     = refs_ff[own_idx];
   assign own_dec     = (own_ref != '0) ? own_ref - 1'b1 : '0;
   assign place_piece = cmd.piece_do && mask_ff[k_ff] && (free_ff >= FREE_W'(2));
   assign place_new   = cmd.new_do && (free_ff != '0);

   // Table write mux
   always_comb begin
      ent_wr_en   = place_piece || place_new;
      ent_wr_addr = low_free;
      if (cmd.new_do) begin
         ent_wr_data = {tag_ff, nr_top_ff, nr_left_ff, nr_bottom_ff, nr_right_ff};
      end else begin
         ent_wr_data = {own_ff, pc_top, pc_left, pc_bottom, pc_right};
      end
   end

   // Release log write
   always_comb begin
      rel_wr_en   = (cmd.dec_do && own_dec == '0) || (cmd.new_do && !place_new);
      rel_wr_data = cmd.new_do ? tag_ff : own_ff;
   end

   // Latch the new rectangle and step through the item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nr_top_ff    <= COORD_BITS'(req_top);
         nr_left_ff   <= COORD_BITS'(req_left);
         nr_bottom_ff <= COORD_BITS'(req_bottom);
         nr_right_ff  <= COORD_BITS'(req_right);
         tag_ff       <= req_tag;
      end
      if (cmd.scan_ev && hit) begin
         old_top_ff    <= rd_top;
         old_left_ff   <= rd_left;
         old_bottom_ff <= rd_bottom;
         old_right_ff  <= rd_right;
         own_ff        <= rd_own;
         mask_ff       <= {rd_right > nr_right_ff, rd_left < nr_left_ff,
                           rd_bottom > nr_bottom_ff, rd_top < nr_top_ff};
      end
   end

   // Per-item counters
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         k_ff       <= '0;
         dropped_ff <= 1'b0;
         rel_cnt_ff <= '0;
         emit_ff    <= '0;
      end else begin
         if (cmd.load) begin
            idx_ff     <= '0;
            dropped_ff <= 1'b0;
            rel_cnt_ff <= '0;
            emit_ff    <= '0;
         end
         if (cmd.scan_next) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.scan_ev) begin
            k_ff <= '0;
         end
         if (cmd.piece_do) begin
            k_ff <= k_ff + 1'b1;
            if (mask_ff[k_ff] && !place_piece) begin
               dropped_ff <= 1'b1;
            end
         end
         if (cmd.new_do && !place_new) begin
            dropped_ff <= 1'b1;
         end
         if (rel_wr_en) begin
            rel_cnt_ff <= rel_cnt_ff + 1'b1;
         end
         if (cmd.emit_ld) begin
            emit_ff <= emit_ff + 1'b1;
         end
      end
   end

   // Valid bits and free count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         free_ff  <= FREE_W'(RECT_SLOTS);
      end else if (cmd.scan_ev && hit) begin
         valid_ff[idx_ff] <= 1'b0;
         free_ff          <= free_ff + 1'b1;
      end else if (ent_wr_en) begin
         valid_ff[low_free] <= 1'b1;
         free_ff            <= free_ff - 1'b1;
      end
   end

   // Owner counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TAG_SLOTS; t++) begin
            refs_ff[t] <= '0;
         end
      end else if (place_piece) begin
         refs_ff[own_idx] <= own_ref + 1'b1;
      end else if (cmd.dec_do) begin
         refs_ff[own_idx] <= own_dec;
      end else if (cmd.new_do) begin
         refs_ff[tag_idx] <= place_new ? REF_W'(1) : '0;
      end
   end

   // Output register: load one result, drop it once taken
   logic rel_none, rel_last;
   assign rel_none = (rel_cnt_ff == '0);
   assign rel_last = rel_none || (emit_ff == rel_cnt_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_ld) begin
         rsp_tag_ff  <= rel_none ? '0 : rel_rd_data;
         rsp_rel_ff  <= !rel_none;
         rsp_last_ff <= rel_last;
         if (sts.empty) begin
            rsp_status_ff <= STATUS_EMPTY;
         end else begin
            rsp_status_ff <= dropped_ff ? STATUS_DROPPED : STATUS_STORED;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tag       = rsp_tag_ff;
   assign rsp_rel_valid = rsp_rel_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

   // Status to the controller
   always_comb begin
      sts.empty      = (nr_left_ff >= nr_right_ff) || (nr_top_ff >= nr_bottom_ff);
      sts.scan_valid = valid_ff[idx_ff];
      sts.scan_last  = (idx_ff == SLOT_W'(RECT_SLOTS - 1));
      sts.hit        = hit;
      sts.piece_last = (k_ff == 2'd3);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
      sts.rel_last   = rel_last;
   end
endmodule

// File: rtl/core/occluding_rect_list_splitter.sv
// Occluding rectangle list splitter, top level.
// Depends on orls_pkg, orls_if, orls_ctrl, orls_dp and orls_ram.
//
// Request channel (req_chan): one item is a rectangle (top/left inclusive,
// bottom/right exclusive) and its owner tag. The block takes one item at a
// time; req_chan.ready is high only while no item is in flight.
// Response channel (rsp_chan): one item per released tag, or a single item
// with release_valid low when nothing was released; last_item marks the
// final item of a request and all items of a request carry the same status.
// Steps: latch and check, then a scan over the table slots; each overlapped
// slot adds four piece steps and the count update; then the new rectangle
// is stored and the response items are emitted. An empty rectangle skips
// the scan and the store. With 32 slots an item releases up to 33 tags.
// Reset (synchronous, active high) clears the table valid bits, the owner
// counts and the output valid flag; table contents need no clearing pass.
// A stalled response holds in the output register; the block waits and the
// next request is taken once the last response item has been loaded.
module occluding_rect_list_splitter #(
   parameter int RECT_SLOTS = 32,
   parameter int TAG_SLOTS  = 32,
   parameter int COORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   orls_req_if.sink   req_chan,
   orls_rsp_if.source rsp_chan
);
   import orls_pkg::*;

   orls_cmd_type cmd;
   orls_sts_type sts;

   orls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   orls_dp #(
      .RECT_SLOTS (RECT_SLOTS),
      .TAG_SLOTS  (TAG_SLOTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_top       (req_chan.rect_top),
      .req_left      (req_chan.rect_left),
      .req_bottom    (req_chan.rect_bottom),
      .req_right     (req_chan.rect_right),
      .req_tag       (req_chan.owner_tag),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_tag       (rsp_chan.released_tag),
      .rsp_rel_valid (rsp_chan.release_valid),
      .rsp_last      (rsp_chan.last_item),
      .rsp_status    (rsp_chan.status)
   );

`ifndef SYNTH
   // Block is ready after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_chan.ready)
      else $error("not ready after reset");

   // Accepting an item closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("ready stayed high after accept");

   // Piece and new-rectangle writes never coincide
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.piece_do && cmd.new_do))
      else $error("two table writers in one cycle");

   // A response item is loaded only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_ld |-> sts.out_free)
      else $error("response overwritten");
`endif
endmodule
